FILE: design/bfn_pkg.sv
package bfn_pkg;

  localparam int unsigned GRID_POINTS_DEF    = 128;
  localparam int unsigned MAX_ITERATIONS_DEF = 100;
  localparam int unsigned FRICTION_SHAPE_DEF = 100;
  localparam int unsigned STOP_THRESHOLD_DEF = 13;

  localparam int unsigned NUM_REGS = 8;
  localparam int unsigned REG_IW   = 3;
  localparam int unsigned NUM_SMP  = 9;
  localparam int unsigned IN_W     = 304;
  localparam int unsigned OUT_W    = 48;

  localparam logic signed [63:0] ONE_Q27    = 64'sd134217728;
  localparam logic signed [63:0] EXP_M1_Q27 = 64'sd49375943;
  localparam logic signed [63:0] S64_MAX    = 64'h7fff_ffff_ffff_ffff;
  localparam logic signed [63:0] S64_MIN    = 64'h8000_0000_0000_0000;

  // register indexes
  localparam logic [REG_IW-1:0] REG_PREV_CENTER  = 3'd0;
  localparam logic [REG_IW-1:0] REG_PREV_NEAR    = 3'd1;
  localparam logic [REG_IW-1:0] REG_PREV_FAR     = 3'd2;
  localparam logic [REG_IW-1:0] REG_OLDER_CENTER = 3'd3;
  localparam logic [REG_IW-1:0] REG_OLDER_NEAR   = 3'd4;
  localparam logic [REG_IW-1:0] REG_LINEAR       = 3'd5;
  localparam logic [REG_IW-1:0] REG_FRICTION     = 3'd6;
  localparam logic [REG_IW-1:0] REG_OUTPUT       = 3'd7;

  typedef enum logic [3:0] {
    OP_BIAS, OP_LIN27, OP_SQ, OP_SHAPE, OP_EXPI, OP_EZERO, OP_EXPM, OP_VE,
    OP_G1, OP_G2, OP_D, OP_DG, OP_DIV, OP_EXC
  } op_t;

  typedef enum logic [1:0] {SH0, SH23, SH24, SH27} sh_t;

  typedef struct packed {
    logic       start;
    op_t        op;
    logic [3:0] term;
    logic       capture;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic exp_big;
    logic cnt_zero;
    logic stop;
    logic out_free;
  } sts_t;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] r;
    r = a + b;
    if (!a[63] && !b[63] && r[63]) return S64_MAX;
    if (a[63] && b[63] && !r[63]) return S64_MIN;
    return r;
  endfunction

  function automatic logic signed [63:0] sat_neg(input logic signed [63:0] a);
    if (a == S64_MIN) return S64_MAX;
    return -a;
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] a);
    if (!a[63] && (|a[62:31])) return 32'h7fff_ffff;
    if (a[63] && !(&a[62:31])) return 32'h8000_0000;
    return a[31:0];
  endfunction

  // magnitude plus overflow flag back to a saturated signed value
  function automatic logic signed [63:0] apply_sign(input logic hi_nz,
                                                    input logic [63:0] lo,
                                                    input logic neg);
    if (neg) begin
      if (hi_nz || lo > 64'h8000_0000_0000_0000) return S64_MIN;
      return -$signed(lo);
    end
    if (hi_nz || lo[63]) return S64_MAX;
    return $signed(lo);
  endfunction

  // exp(-i/16) in q.27
  function automatic logic [27:0] exp_tab(input logic [4:0] i);
    logic [27:0] v;
    case (i)
      5'd0:    v = 28'd134217728;
      5'd1:    v = 28'd126085887;
      5'd2:    v = 28'd118446729;
      5'd3:    v = 28'd111270405;
      5'd4:    v = 28'd104528872;
      5'd5:    v = 28'd98195788;
      5'd6:    v = 28'd92246405;
      5'd7:    v = 28'd86657478;
      5'd8:    v = 28'd81407167;
      5'd9:    v = 28'd76474956;
      5'd10:   v = 28'd71841573;
      5'd11:   v = 28'd67488912;
      5'd12:   v = 28'd63399966;
      5'd13:   v = 28'd59558756;
      5'd14:   v = 28'd55950273;
      5'd15:   v = 28'd52560418;
      5'd16:   v = 28'd49375943;
      default: v = 28'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: design/bfn_mul.sv
module bfn_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  input  bfn_pkg::sh_t       sh,
  output logic               done,
  output logic signed [63:0] p
);
  import bfn_pkg::*;

  logic [63:0]  ua, ub;
  logic [63:0]  ua_r, ub_r;
  logic         neg_r;
  sh_t          sh_r;
  logic [127:0] acc_r;
  logic [2:0]   cnt_r;
  logic         busy_r, done_r;
  logic signed [63:0] p_r;
  logic [31:0]  pa, pb;
  logic [63:0]  pp;
  logic [127:0] pp_s, sr;

  assign ua = a[63] ? 64'(-a) : 64'(a);
  assign ub = b[63] ? 64'(-b) : 64'(b);

  // one 32x32 partial product a cycle
  assign pa = cnt_r[0] ? ua_r[63:32] : ua_r[31:0];
  assign pb = cnt_r[1] ? ub_r[63:32] : ub_r[31:0];
  assign pp = pa * pb;

  always_comb begin
    unique case (cnt_r[1:0])
      2'd0:    pp_s = {64'd0, pp};
      2'd3:    pp_s = {pp, 64'd0};
      default: pp_s = {32'd0, pp, 32'd0};
    endcase
  end

  always_comb begin
    unique case (sh_r)
      SH0:  sr = acc_r;
      SH23: sr = acc_r >> 23;
      SH24: sr = acc_r >> 24;
      SH27: sr = acc_r >> 27;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        acc_r  <= '0;
        ua_r   <= ua;
        ub_r   <= ub;
        neg_r  <= a[63] ^ b[63];
        sh_r   <= sh;
      end else if (busy_r) begin
        if (cnt_r == 3'd4) begin
          p_r    <= apply_sign(|sr[127:64], sr[63:0], neg_r);
          done_r <= 1'b1;
          busy_r <= 1'b0;
        end else begin
          acc_r <= acc_r + pp_s;
          cnt_r <= cnt_r + 3'd1;
        end
      end
    end
  end

  assign done = done_r;
  assign p    = p_r;

endmodule

FILE: design/bfn_div.sv
module bfn_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic signed [63:0] den,
  output logic               done,
  output logic signed [63:0] q
);
  import bfn_pkg::*;

  logic [63:0]  un, ud;
  logic [63:0]  ud_r, rem_r, rs;
  logic [127:0] dq_r;
  logic [7:0]   cnt_r;
  logic         busy_r, done_r, neg_r, ge;
  logic signed [63:0] q_r;

  assign un = num[63] ? 64'(-num) : 64'(num);
  assign ud = den[63] ? 64'(-den) : 64'(den);

  // restoring division, one quotient bit a cycle
  assign rs = {rem_r[62:0], dq_r[127]};
  assign ge = rs >= ud_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        if (den == 64'sd0) begin
          q_r    <= num[63] ? S64_MIN : ((num == 64'sd0) ? 64'sd0 : S64_MAX);
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
          cnt_r  <= '0;
          rem_r  <= '0;
          dq_r   <= {37'd0, un, 27'd0};
          ud_r   <= ud;
          neg_r  <= num[63] ^ den[63];
        end
      end else if (busy_r) begin
        if (cnt_r == 8'd128) begin
          q_r    <= apply_sign(|dq_r[127:64], dq_r[63:0], neg_r);
          done_r <= 1'b1;
          busy_r <= 1'b0;
        end else begin
          rem_r <= ge ? rs - ud_r : rs;
          dq_r  <= {dq_r[126:0], ge};
          cnt_r <= cnt_r + 8'd1;
        end
      end
    end
  end

  assign done = done_r;
  assign q    = q_r;

endmodule

FILE: design/bfn_datapath.sv
module bfn_datapath #(
  parameter int unsigned GRID_POINTS    = bfn_pkg::GRID_POINTS_DEF,
  parameter int unsigned MAX_ITERATIONS = bfn_pkg::MAX_ITERATIONS_DEF,
  parameter int unsigned FRICTION_SHAPE = bfn_pkg::FRICTION_SHAPE_DEF,
  parameter int unsigned STOP_THRESHOLD = bfn_pkg::STOP_THRESHOLD_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bfn_pkg::cmd_t               cmd,
  output bfn_pkg::sts_t               sts,
  input  logic [bfn_pkg::IN_W-1:0]    in_tdata,
  input  logic                        cfg_wr_en,
  input  logic [bfn_pkg::REG_IW-1:0]  cfg_index,
  input  logic [63:0]                 cfg_data,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [bfn_pkg::OUT_W-1:0]   out_tdata
);
  import bfn_pkg::*;

  logic signed [63:0] cfg_r [NUM_REGS];
  logic signed [31:0] smp_r [NUM_SMP];
  logic [6:0]         idx_r;

  logic signed [63:0] b_r, lin27_r, x_r, e_r, ve_r, g_r, tmp_r, dg_r;
  logic signed [31:0] v_r, exc_r;
  logic [4:0]         ecnt_r;
  logic [7:0]         it_r;
  logic               conv_r;
  op_t                op_r;
  logic [3:0]         term_r;
  logic               quick_r;

  logic [6:0]         oidx_r, oit_r;
  logic signed [31:0] oexc_r;
  logic               oconv_r, out_valid_r;

  logic [31:0]        gprod;
  logic [15:0]        gi, gi_c;

  logic signed [63:0] ma, mb, mp, dq, v64, d, coef;
  sh_t                msh;
  logic               mul_go, div_go, mul_done, div_done, done;
  logic [27:0]        ti, tn;
  logic signed [31:0] vn;
  logic [32:0]        diff, dmag;

  assign v64 = {{32{v_r[31]}}, v_r};
  assign d   = ONE_Q27 - (x_r <<< 1);
  assign ti  = exp_tab({1'b0, x_r[26:23]});
  assign tn  = exp_tab({1'b0, x_r[26:23]} + 5'd1);

  // grid point from bow position
  assign gprod = {16'd0, in_tdata[15:0]} * 32'(GRID_POINTS);
  assign gi    = gprod[31:16];
  always_comb begin
    if (gi > 16'(GRID_POINTS - 2)) gi_c = 16'(GRID_POINTS - 2);
    else if (gi < 16'd2)           gi_c = 16'd2;
    else                           gi_c = gi;
  end

  always_comb begin
    unique case (cmd.term)
      4'd0:         coef = cfg_r[REG_LINEAR];
      4'd1:         coef = cfg_r[REG_PREV_CENTER];
      4'd2, 4'd3:   coef = cfg_r[REG_PREV_NEAR];
      4'd4, 4'd5:   coef = cfg_r[REG_PREV_FAR];
      4'd6:         coef = cfg_r[REG_OLDER_CENTER];
      default:      coef = cfg_r[REG_OLDER_NEAR];
    endcase
  end

  // operand routing for the shared multiplier
  always_comb begin
    ma  = 64'sd0;
    mb  = 64'sd0;
    msh = SH24;
    unique case (cmd.op)
      OP_BIAS: begin
        ma = coef;
        mb = (cmd.term < 4'(NUM_SMP)) ? 64'(smp_r[cmd.term]) : 64'sd0;
      end
      OP_LIN27: begin ma = cfg_r[REG_LINEAR]; mb = ONE_Q27; end
      OP_SQ:    begin ma = v64; mb = v64; msh = SH27; end
      OP_SHAPE: begin ma = x_r; mb = 64'(FRICTION_SHAPE); msh = SH0; end
      OP_EXPI: begin
        ma  = $signed({36'd0, ti - tn});
        mb  = $signed({41'd0, x_r[22:0]});
        msh = SH23;
      end
      OP_EXPM:  begin ma = e_r; mb = EXP_M1_Q27; msh = SH27; end
      OP_VE:    begin ma = v64; mb = e_r; msh = SH27; end
      OP_G1:    begin ma = cfg_r[REG_LINEAR]; mb = v64; end
      OP_G2:    begin ma = cfg_r[REG_FRICTION]; mb = ve_r; end
      OP_D:     begin ma = d; mb = e_r; msh = SH27; end
      OP_DG:    begin ma = cfg_r[REG_FRICTION]; mb = tmp_r; end
      OP_EXC:   begin ma = cfg_r[REG_OUTPUT]; mb = ve_r; end
      default: ;
    endcase
  end

  assign mul_go = cmd.start && cmd.op != OP_DIV && cmd.op != OP_EZERO;
  assign div_go = cmd.start && cmd.op == OP_DIV;

  bfn_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_go),
    .a     (ma),
    .b     (mb),
    .sh    (msh),
    .done  (mul_done),
    .p     (mp)
  );

  bfn_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_go),
    .num   (g_r),
    .den   (dg_r),
    .done  (div_done),
    .q     (dq)
  );

  assign done = mul_done | div_done | quick_r;

  // newton update and step size
  assign vn   = clamp32(sat_add(v64, sat_neg(dq)));
  assign diff = {vn[31], vn} - {v_r[31], v_r};
  assign dmag = diff[32] ? -diff : diff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) cfg_r[i] <= 64'sd0;
      quick_r     <= 1'b0;
      out_valid_r <= 1'b0;
      it_r        <= '0;
      conv_r      <= 1'b0;
    end else begin
      if (cfg_wr_en) cfg_r[cfg_index] <= cfg_data;
      quick_r <= cmd.start && cmd.op == OP_EZERO;
      if (cmd.start) begin
        op_r   <= cmd.op;
        term_r <= cmd.term;
      end
      if (cmd.capture) begin
        for (int i = 0; i < NUM_SMP; i++) smp_r[i] <= in_tdata[16 + 32*i +: 32];
        idx_r  <= gi_c[6:0];
        v_r    <= '0;
        it_r   <= '0;
        conv_r <= 1'b0;
      end
      if (done) begin
        unique case (op_r)
          OP_BIAS:  b_r <= (term_r == 4'd0) ? mp : sat_add(b_r, mp);
          OP_LIN27: lin27_r <= mp;
          OP_SQ, OP_SHAPE: x_r <= mp;
          OP_EXPI: begin
            e_r    <= $signed({36'd0, ti}) - mp;
            ecnt_r <= x_r[31:27];
          end
          OP_EZERO: begin
            e_r    <= 64'sd0;
            ecnt_r <= '0;
          end
          OP_EXPM: begin
            e_r    <= mp;
            ecnt_r <= ecnt_r - 5'd1;
          end
          OP_VE:    ve_r <= mp;
          OP_G1:    g_r <= mp;
          OP_G2:    g_r <= sat_add(sat_add(g_r, mp), b_r);
          OP_D:     tmp_r <= mp;
          OP_DG:    dg_r <= sat_add(lin27_r, mp);
          OP_DIV: begin
            v_r    <= vn;
            it_r   <= it_r + 8'd1;
            conv_r <= dmag < 33'(STOP_THRESHOLD);
          end
          OP_EXC:   exc_r <= clamp32(mp);
        endcase
      end
      // output word holds until taken
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
        oidx_r      <= idx_r;
        oexc_r      <= exc_r;
        oit_r       <= it_r[6:0];
        oconv_r     <= conv_r;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.done     = done;
  assign sts.exp_big  = |x_r[63:32];
  assign sts.cnt_zero = ecnt_r == 5'd0;
  assign sts.stop     = conv_r || it_r == 8'(MAX_ITERATIONS);
  assign sts.out_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, oconv_r, oit_r, oexc_r, oidx_r};

  a_units_apart: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_done && div_done))
    else $error("multiplier and divider finished together");

  a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    it_r <= 8'(MAX_ITERATIONS))
    else $error("iteration count beyond limit");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("loaded word not presented");

endmodule

FILE: design/bfn_ctrl.sv
module bfn_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output bfn_pkg::cmd_t cmd,
  input  bfn_pkg::sts_t sts
);
  import bfn_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_ISSUE  = 5'b00010,
    S_WAIT   = 5'b00100,
    S_DECIDE = 5'b01000,
    S_FIN    = 5'b10000
  } state_t;

  state_t     state_r, state_nxt;
  op_t        op_r, op_nxt;
  logic [3:0] term_r, term_nxt;
  logic       final_r, final_nxt;
  logic       capture;

  assign in_tready = state_r == S_IDLE;
  assign capture   = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    term_nxt  = term_r;
    final_nxt = final_r;
    unique case (state_r)
      S_IDLE: begin
        if (capture) begin
          state_nxt = S_ISSUE;
          op_nxt    = OP_BIAS;
          term_nxt  = '0;
          final_nxt = 1'b0;
        end
      end
      S_ISSUE: state_nxt = S_WAIT;
      S_WAIT: begin
        if (sts.done) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        state_nxt = S_ISSUE;
        unique case (op_r)
          OP_BIAS: begin
            if (term_r == 4'(NUM_SMP - 1)) op_nxt = OP_LIN27;
            else term_nxt = term_r + 4'd1;
          end
          OP_LIN27: op_nxt = OP_SQ;
          OP_SQ:    op_nxt = OP_SHAPE;
          OP_SHAPE: op_nxt = sts.exp_big ? OP_EZERO : OP_EXPI;
          OP_EXPI, OP_EXPM: op_nxt = sts.cnt_zero ? OP_VE : OP_EXPM;
          OP_EZERO: op_nxt = OP_VE;
          OP_VE:    op_nxt = final_r ? OP_EXC : OP_G1;
          OP_G1:    op_nxt = OP_G2;
          OP_G2:    op_nxt = OP_D;
          OP_D:     op_nxt = OP_DG;
          OP_DG:    op_nxt = OP_DIV;
          OP_DIV: begin
            op_nxt    = OP_SQ;
            final_nxt = sts.stop;
          end
          OP_EXC:   state_nxt = S_FIN;
        endcase
      end
      S_FIN: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_BIAS;
      term_r  <= '0;
      final_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      term_r  <= term_nxt;
      final_r <= final_nxt;
    end
  end

  assign cmd.start    = state_r == S_ISSUE;
  assign cmd.op       = op_r;
  assign cmd.term     = term_r;
  assign cmd.capture  = capture;
  assign cmd.load_out = state_r == S_FIN && sts.out_free;

  a_no_stray_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !sts.done)
    else $error("unit finished with no operation pending");

  a_single_issue: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> !cmd.start)
    else $error("operation issued twice");

endmodule

FILE: design/bow_friction_newton_solver.sv
// channel  dir  handshake             payload
// in_      in   in_tvalid/in_tready   in_tdata: 304 bits, sample word
// out_     out  out_tvalid/out_tready out_tdata: 48 bits, result word
// cfg_     in   cfg_wr_en             cfg_index (3 bits), cfg_data (64 bits)
//
// one word at a time; the time a word takes depends on k, the number of newton
// steps, and on n, the integer part of the exponent argument, and is set by the
// shared 64x64 multiplier and the radix-2 divider
// rst_n is synchronous, active low, and clears the gain registers to zero
// a finished word waits in the output register; the next word is taken meanwhile
module bow_friction_newton_solver #(
  parameter int unsigned GRID_POINTS    = bfn_pkg::GRID_POINTS_DEF,
  parameter int unsigned MAX_ITERATIONS = bfn_pkg::MAX_ITERATIONS_DEF,
  parameter int unsigned FRICTION_SHAPE = bfn_pkg::FRICTION_SHAPE_DEF,
  parameter int unsigned STOP_THRESHOLD = bfn_pkg::STOP_THRESHOLD_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // bow_position, bow_velocity, prev_center, prev_right1, prev_left1,
  // prev_right2, prev_left2, older_center, older_right1, older_left1
  input  logic [bfn_pkg::IN_W-1:0]   in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // grid_index, excitation, iterations_used, converged, zero pad
  output logic [bfn_pkg::OUT_W-1:0]  out_tdata,
  input  logic                       cfg_wr_en,
  input  logic [bfn_pkg::REG_IW-1:0] cfg_index,
  input  logic [63:0]                cfg_data
);
  import bfn_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bfn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  bfn_datapath #(
    .GRID_POINTS    (GRID_POINTS),
    .MAX_ITERATIONS (MAX_ITERATIONS),
    .FRICTION_SHAPE (FRICTION_SHAPE),
    .STOP_THRESHOLD (STOP_THRESHOLD)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
